@@ rtl/lrupr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the LRU page replacement core: default sizes, field widths,
// controller state encoding and the command/status structs. No dependencies.
package lrupr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam int CFG_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 32;

  localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } lrupr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;    // latch reference, clear table on restart
    logic pick;    // register hit / fill / victim selection
    logic commit;  // apply table update and load result register
  } lrupr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_full;  // result register holds a result that is not taken this cycle
  } lrupr_sts_t;

endpackage

@@ rtl/lrupr_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the LRU page replacement core.
// Depends on lrupr_pkg.
interface lrupr_req_if
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 restart;

  modport source (output valid, output page, output restart, input ready);
  modport sink   (input valid, input page, input restart, output ready);
endinterface

interface lrupr_rsp_if
  import lrupr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] fault_count;

  modport source (output valid, output hit, output slot, output fault_count, input ready);
  modport sink   (input valid, input hit, input slot, input fault_count, output ready);
endinterface

@@ rtl/lru_page_replacement_core.sv @@
`timescale 1ns / 1ps
// Top level of the LRU page replacement core: controller and datapath.
// Depends on lrupr_pkg, lrupr_if, lrupr_ctrl and lrupr_dp.
//
// Usage:
//   req carries one page reference (page, restart) per transfer; rsp returns
//   one result (hit, slot, fault_count) per reference, in order.
//   cfg_we/cfg_wdata write frames_in_use (0 acts as 1, values above FRAMES
//   act as FRAMES); write it only while no reference is in flight.
//   restart clears the frame table and fault count before that reference.
// Sequence:
//   A reference passes three steps: accept, associative search with the LRU
//   victim tree, then table update into the result register. The result is
//   valid in the cycle after the update; a new reference is accepted only
//   after the last one has left the update step of the three-step sequencer.
// Reset:
//   rst (synchronous) empties the table, zeroes the fault count and sets
//   frames_in_use to 16.
// Stall:
//   A held result does not block the next accept or search; the update step
//   waits until the result register is free.
module lru_page_replacement_core
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  lrupr_req_if.sink        req,
  lrupr_rsp_if.source      rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  lrupr_cmd_t cmd;
  lrupr_sts_t sts;

  lrupr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrupr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_page         (req.page),
    .in_restart      (req.restart),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_hit         (rsp.hit),
    .out_slot        (rsp.slot),
    .out_fault_count (rsp.fault_count)
  );

endmodule

@@ rtl/lrupr_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the LRU page replacement core: accept, search, update.
// Depends on lrupr_pkg.
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lrupr_sts_t sts,
  output lrupr_cmd_t cmd
);

  lrupr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    in_ready   = (state == S_IDLE);
    cmd.take   = in_valid && (state == S_IDLE);
    cmd.pick   = (state == S_SEARCH);
    cmd.commit = (state == S_UPDATE) && !sts.out_full;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!sts.out_full) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_take_search: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == S_SEARCH)
    else $error("accepted transfer did not start a search");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) && sts.out_full |=> state == S_UPDATE)
    else $error("update left while result register full");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.pick, cmd.commit}))
    else $error("more than one datapath command at once");

endmodule

@@ rtl/lrupr_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the LRU page replacement core: frame table (valid, page, rank),
// associative match, LRU victim tree, fault counter and result register.
// Depends on lrupr_pkg.
module lrupr_dp
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lrupr_cmd_t           cmd,
  output lrupr_sts_t           sts,
  input  logic [PAGE_BITS-1:0] in_page,
  input  logic                 in_restart,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [COUNT_W-1:0]   out_fault_count
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int AGE_W  = IDX_W;
  localparam int LEAVES = 1 << IDX_W;
  localparam int LIM_W  = 7;  // holds any frame index up to 127

  typedef struct packed {
    logic             v;
    logic [AGE_W-1:0] age;
    logic [IDX_W-1:0] idx;
  } cand_t;

  logic [CFG_W-1:0]     frames_in_use;
  logic [FRAMES-1:0]    frame_valid;
  logic [AGE_W-1:0]     frame_age  [FRAMES];
  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [COUNT_W-1:0]   faults;

  logic [PAGE_BITS-1:0] page_q;
  logic [IDX_W-1:0]     slot_q;
  logic                 hit_q;
  logic                 fill_q;

  logic [FRAMES-1:0]    in_use, hit_vec, empty_vec;
  logic [IDX_W-1:0]     hit_idx, empty_idx, sel_idx;
  logic                 hit_any, empty_any;
  cand_t                node [1:2*LEAVES-1];
  logic [LIM_W-1:0]     use_lim;
  logic [COUNT_W-1:0]   faults_inc;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RST;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // frames 0 .. max(cfg,1)-1 take part; frames past FRAMES do not exist
  always_comb begin
    use_lim = {{(LIM_W-CFG_W){1'b0}}, frames_in_use};
    for (int j = 0; j < FRAMES; j++) begin
      in_use[j]    = (j == 0) || (LIM_W'(j) < use_lim);
      hit_vec[j]   = frame_valid[j] && in_use[j] && (frame_page[j] == page_q);
      empty_vec[j] = !frame_valid[j] && in_use[j];
    end
    hit_any   = |hit_vec;
    empty_any = |empty_vec;
    hit_idx   = '0;
    empty_idx = '0;
    for (int j = FRAMES - 1; j >= 0; j--) begin
      if (hit_vec[j])   hit_idx   = IDX_W'(j);
      if (empty_vec[j]) empty_idx = IDX_W'(j);
    end
  end

  // oldest frame in use; ties keep the lower index
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < FRAMES) begin
        node[LEAVES+i].v   = in_use[i];
        node[LEAVES+i].age = frame_age[i];
      end else begin
        node[LEAVES+i].v   = 1'b0;
        node[LEAVES+i].age = '0;
      end
      node[LEAVES+i].idx = IDX_W'(i);
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (!node[2*n+1].v) begin
        node[n] = node[2*n];
      end else if (!node[2*n].v) begin
        node[n] = node[2*n+1];
      end else if (node[2*n+1].age > node[2*n].age) begin
        node[n] = node[2*n+1];
      end else begin
        node[n] = node[2*n];
      end
    end
    sel_idx = hit_any ? hit_idx : (empty_any ? empty_idx : node[1].idx);
  end

  always_ff @(posedge clk) begin
    if (cmd.take) page_q <= in_page;
    if (cmd.pick) begin
      slot_q <= sel_idx;
      hit_q  <= hit_any;
      fill_q <= !hit_any && empty_any;
    end
  end

  assign faults_inc = (faults == COUNT_MAX) ? faults : faults + COUNT_W'(1);

  // frame table and fault count
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      faults      <= '0;
      for (int j = 0; j < FRAMES; j++) frame_age[j] <= '0;
    end else if (cmd.take && in_restart) begin
      frame_valid <= '0;
      faults      <= '0;
      for (int j = 0; j < FRAMES; j++) frame_age[j] <= '0;
    end else if (cmd.commit) begin
      // a fill ages every valid frame; otherwise only those younger than the touched one
      for (int j = 0; j < FRAMES; j++) begin
        if (frame_valid[j] && (IDX_W'(j) != slot_q) &&
            (fill_q || (frame_age[j] < frame_age[slot_q]))) begin
          frame_age[j] <= frame_age[j] + AGE_W'(1);
        end
      end
      frame_age[slot_q]   <= '0;
      frame_valid[slot_q] <= 1'b1;
      if (!hit_q) faults <= faults_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_q) frame_page[slot_q] <= page_q;
  end

  // result register
  assign slot_ext = {{SLOT_W{1'b0}}, slot_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit         <= hit_q;
      out_slot        <= slot_ext[SLOT_W-1:0];
      out_fault_count <= hit_q ? faults : faults_inc;
    end
  end

  assign sts.out_full = out_valid && !out_ready;

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> frame_valid[slot_q] && (frame_age[slot_q] == '0))
    else $error("committed frame not valid and youngest");

  a_fault_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !hit_q |=> (faults != '0) && (out_fault_count == faults))
    else $error("fault not counted");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && hit_q |=> $stable(faults))
    else $error("fault count moved on a hit");

endmodule
